/* src/idq_pkg.sv */
package idq_pkg;

    // Storage geometry of each stack.
    localparam int SIDE_DEPTH = 256;
    localparam int ELEM_WIDTH = 32;

    // Derived widths.
    localparam int ADDR_W = $clog2(SIDE_DEPTH);
    localparam int CNT_W  = $clog2(SIDE_DEPTH + 1);
    localparam int SIZE_W = CNT_W + 1;
    localparam int POS_W  = 9;
    localparam int CMP_W  = (SIZE_W > POS_W) ? SIZE_W : POS_W;

    // Command codes.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_READ_IDX   = 3'd2;
    localparam logic [2:0] CMD_WRITE_IDX  = 3'd3;
    localparam logic [2:0] CMD_FRONT      = 3'd4;
    localparam logic [2:0] CMD_BACK       = 3'd5;

    // Input item.
    typedef struct packed {
        logic [2:0]       cmd;
        logic [POS_W-1:0] position;
        logic [31:0]      item_value;
    } dq_in_t;

    // Result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic [9:0]  occupancy;
        logic        is_empty;
        logic        fault;
    } dq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dq_ctrl_t;

endpackage

/* src/idq_ram.sv */
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port: a write, or a read whose data is registered.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* src/idq_ctrl.sv */
module idq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output idq_pkg::dq_ctrl_t ctrl
);
    import idq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // The output register is free when empty or being taken this cycle.
    logic out_free;
    assign out_free = !rsp_valid_reg || rsp_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    ctrl.load_out  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* src/idq_datapath.sv */
module idq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  idq_pkg::dq_ctrl_t ctrl,
    input  idq_pkg::dq_in_t   cmd_item,
    output idq_pkg::dq_out_t  rsp_item
);
    import idq_pkg::*;

    // Latched command.
    logic [2:0]            cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ELEM_WIDTH-1:0] val_reg;

    // Stack counts.
    logic [CNT_W-1:0] front_cnt_reg;
    logic [CNT_W-1:0] front_cnt_next;
    logic [CNT_W-1:0] back_cnt_reg;
    logic [CNT_W-1:0] back_cnt_next;

    // Outcome of the execute step, used when the result is formed.
    logic fault_reg;
    logic fault_next;
    logic is_read_reg;
    logic is_read_next;
    logic sel_back_reg;
    logic sel_back_next;

    dq_out_t rsp_reg;

    // Memory ports.
    logic                  front_en;
    logic                  front_we;
    logic [ADDR_W-1:0]     front_addr;
    logic [ELEM_WIDTH-1:0] front_rdata;
    logic                  back_en;
    logic                  back_we;
    logic [ADDR_W-1:0]     back_addr;
    logic [ELEM_WIDTH-1:0] back_rdata;

    // Index arithmetic.
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] front_ext;
    logic [CMP_W-1:0] front_idx;
    logic [CMP_W-1:0] back_idx;
    logic             in_range;
    logic             in_front;
    logic             front_full;
    logic             back_full;

    assign front_ext  = CMP_W'(front_cnt_reg);
    assign size_ext   = front_ext + CMP_W'(back_cnt_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign in_range   = pos_ext < size_ext;
    assign in_front   = pos_ext < front_ext;
    assign front_idx  = front_ext - CMP_W'(1) - pos_ext;
    assign back_idx   = pos_ext - front_ext;
    assign front_full = (front_cnt_reg == CNT_W'(SIDE_DEPTH));
    assign back_full  = (back_cnt_reg == CNT_W'(SIDE_DEPTH));

    // Decode the latched command into at most one memory access and count update.
    always_comb
    begin
        front_en       = 1'b0;
        front_we       = 1'b0;
        front_addr     = '0;
        back_en        = 1'b0;
        back_we        = 1'b0;
        back_addr      = '0;
        front_cnt_next = front_cnt_reg;
        back_cnt_next  = back_cnt_reg;
        fault_next     = 1'b0;
        is_read_next   = 1'b0;
        sel_back_next  = 1'b0;
        if (ctrl.exec)
        begin
            unique case (cmd_reg) inside
                CMD_PUSH_FRONT:
                begin
                    if (front_full)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        front_en       = 1'b1;
                        front_we       = 1'b1;
                        front_addr     = front_cnt_reg[ADDR_W-1:0];
                        front_cnt_next = front_cnt_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (back_full)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        back_en       = 1'b1;
                        back_we       = 1'b1;
                        back_addr     = back_cnt_reg[ADDR_W-1:0];
                        back_cnt_next = back_cnt_reg + CNT_W'(1);
                    end
                end
                CMD_READ_IDX, CMD_WRITE_IDX:
                begin
                    if (!in_range)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        is_read_next  = (cmd_reg == CMD_READ_IDX);
                        sel_back_next = !in_front;
                        if (in_front)
                        begin
                            front_en   = 1'b1;
                            front_we   = (cmd_reg == CMD_WRITE_IDX);
                            front_addr = front_idx[ADDR_W-1:0];
                        end
                        else
                        begin
                            back_en   = 1'b1;
                            back_we   = (cmd_reg == CMD_WRITE_IDX);
                            back_addr = back_idx[ADDR_W-1:0];
                        end
                    end
                end
                CMD_FRONT:
                begin
                    if (size_ext == '0)
                    begin
                        fault_next = 1'b1;
                    end
                    else if (front_cnt_reg != '0)
                    begin
                        is_read_next = 1'b1;
                        front_en     = 1'b1;
                        front_addr   = front_ext[ADDR_W-1:0] - ADDR_W'(1);
                    end
                    else
                    begin
                        is_read_next  = 1'b1;
                        sel_back_next = 1'b1;
                        back_en       = 1'b1;
                    end
                end
                CMD_BACK:
                begin
                    if (size_ext == '0)
                    begin
                        fault_next = 1'b1;
                    end
                    else if (back_cnt_reg != '0)
                    begin
                        is_read_next  = 1'b1;
                        sel_back_next = 1'b1;
                        back_en       = 1'b1;
                        back_addr     = back_cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                    end
                    else
                    begin
                        is_read_next = 1'b1;
                        front_en     = 1'b1;
                    end
                end
                default:
                begin
                    fault_next = 1'b1;
                end
            endcase
        end
    end

    // Stack storage.
    idq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .en    (front_en),
        .we    (front_we),
        .addr  (front_addr),
        .wdata (val_reg),
        .rdata (front_rdata)
    );

    idq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .en    (back_en),
        .we    (back_we),
        .addr  (back_addr),
        .wdata (val_reg),
        .rdata (back_rdata)
    );

    // Counts are control state and clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
        end
        else
        begin
            front_cnt_reg <= front_cnt_next;
            back_cnt_reg  <= back_cnt_next;
        end
    end

    // Command latch, execute outcome and result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg <= cmd_item.cmd;
            pos_reg <= cmd_item.position;
            val_reg <= ELEM_WIDTH'(cmd_item.item_value);
        end
        if (ctrl.exec)
        begin
            fault_reg    <= fault_next;
            is_read_reg  <= is_read_next;
            sel_back_reg <= sel_back_next;
        end
        if (ctrl.load_out)
        begin
            if (is_read_reg && !fault_reg)
            begin
                rsp_reg.read_data <= sel_back_reg ? 32'(back_rdata) : 32'(front_rdata);
            end
            else
            begin
                rsp_reg.read_data <= '0;
            end
            rsp_reg.occupancy <= 10'(size_ext);
            rsp_reg.is_empty  <= (size_ext == '0);
            rsp_reg.fault     <= fault_reg;
        end
    end

    assign rsp_item = rsp_reg;

endmodule

/* src/indexed_double_ended_queue_unit.sv */
// The item is latched on acceptance, executed in ST_EXEC, and its result is
// registered in ST_RESP once the output register is free. A new item is taken only in
// ST_IDLE; the registered read of the stack RAMs is why ST_RESP follows ST_EXEC.
// Reset: rst_n clears the stack counts and the handshake state at once.
// The stack RAMs are not cleared; only entries written by a push are read.
module indexed_double_ended_queue_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  idq_pkg::dq_in_t  cmd_item,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output idq_pkg::dq_out_t rsp_item
);
    import idq_pkg::*;

    dq_ctrl_t ctrl;

    // Sequencer for the accept, execute and respond steps.
    idq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // Counts, address mapping, stack RAMs and result register.
    idq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd_item (cmd_item),
        .rsp_item (rsp_item)
    );

endmodule

/* tb/indexed_double_ended_queue_unit_tb.sv */
`timescale 1ns / 1ps

module indexed_double_ended_queue_unit_tb;

    import idq_pkg::*;

    // Codes that the block must refuse.
    localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

    localparam logic [31:0] ELEM_MASK =
        (ELEM_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ELEM_WIDTH) - 32'd1);

    localparam int RANDOM_ITEMS   = 1530;
    localparam int QUIET_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    // One row of the directed table: the item and, where it is obvious,
    // the result it must produce.
    typedef struct packed {
        dq_in_t  item;
        logic    has_fixed;
        dq_out_t result;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_ready;
    dq_in_t  cmd_item = '0;
    logic    rsp_valid;
    logic    rsp_ready = 1'b0;
    dq_out_t rsp_item;

    // Shadow copy of the two stacks.
    logic [31:0] shadow_front_mem [SIDE_DEPTH];
    logic [31:0] shadow_back_mem  [SIDE_DEPTH];
    int          shadow_front_count = 0;
    int          shadow_back_count  = 0;

    dq_out_t     expected_responses [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          sender_idle = 1'b1;
    bit          rsp_stall_on = 1'b1;
    dq_out_t     want_rsp;

    indexed_double_ended_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow deque and returns its result.
    function automatic dq_out_t predict_response(input dq_in_t it);
        dq_out_t     r;
        logic [31:0] val;
        int          size;
        int          pos;
        logic        refused;
        r = '0;
        val = it.item_value & ELEM_MASK;
        size = shadow_front_count + shadow_back_count;
        pos = it.position;
        refused = 1'b0;
        case (it.cmd)
            CMD_PUSH_FRONT:
            begin
                if (shadow_front_count >= SIDE_DEPTH)
                    refused = 1'b1;
                else
                begin
                    shadow_front_mem[shadow_front_count] = val;
                    shadow_front_count++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (shadow_back_count >= SIDE_DEPTH)
                    refused = 1'b1;
                else
                begin
                    shadow_back_mem[shadow_back_count] = val;
                    shadow_back_count++;
                end
            end
            CMD_READ_IDX:
            begin
                if (pos >= size)
                    refused = 1'b1;
                else if (pos < shadow_front_count)
                    r.read_data = shadow_front_mem[shadow_front_count - 1 - pos];
                else
                    r.read_data = shadow_back_mem[pos - shadow_front_count];
            end
            CMD_WRITE_IDX:
            begin
                if (pos >= size)
                    refused = 1'b1;
                else if (pos < shadow_front_count)
                    shadow_front_mem[shadow_front_count - 1 - pos] = val;
                else
                    shadow_back_mem[pos - shadow_front_count] = val;
            end
            CMD_FRONT:
            begin
                // With no front pushes, the front is the oldest back push.
                if (size == 0)
                    refused = 1'b1;
                else if (shadow_front_count != 0)
                    r.read_data = shadow_front_mem[shadow_front_count - 1];
                else
                    r.read_data = shadow_back_mem[0];
            end
            CMD_BACK:
            begin
                // With no back pushes, the back is the oldest front push.
                if (size == 0)
                    refused = 1'b1;
                else if (shadow_back_count != 0)
                    r.read_data = shadow_back_mem[shadow_back_count - 1];
                else
                    r.read_data = shadow_front_mem[0];
            end
            default:
            begin
                refused = 1'b1;
            end
        endcase
        if (refused)
            r.read_data = '0;
        size = shadow_front_count + shadow_back_count;
        r.occupancy = 10'(size);
        r.is_empty = (size == 0);
        r.fault = refused;
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] c, input int p, input logic [31:0] v,
                                    input logic has_fixed, input dq_out_t r);
        stim_row_t row;
        row.item.cmd = c;
        row.item.position = POS_W'(p);
        row.item.item_value = v;
        row.has_fixed = has_fixed;
        row.result = r;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offers one item, holding it until accepted, then records its expected result.
    task automatic send_cmd(input dq_in_t it, input logic has_fixed, input dq_out_t fixed_rsp);
        int      gap;
        dq_out_t predicted;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (!(cmd_valid && cmd_ready));
        predicted = predict_response(it);
        expected_responses.insert(expected_responses.size(),
                                  has_fixed ? fixed_rsp : predicted);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_pause();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_responses.size() != 0);
    endtask

    // Result checking and receiver stalls.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("result item with none expected: %h", rsp_item);
                mismatch_count++;
            end
            else
            begin
                want_rsp = expected_responses.pop_front();
                if (rsp_item.read_data !== want_rsp.read_data)
                begin
                    $error("read_data: expected %h, got %h", want_rsp.read_data,
                           rsp_item.read_data);
                    mismatch_count++;
                end
                if (rsp_item.occupancy !== want_rsp.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want_rsp.occupancy,
                           rsp_item.occupancy);
                    mismatch_count++;
                end
                if (rsp_item.is_empty !== want_rsp.is_empty)
                begin
                    $error("is_empty: expected %b, got %b", want_rsp.is_empty,
                           rsp_item.is_empty);
                    mismatch_count++;
                end
                if (rsp_item.fault !== want_rsp.fault)
                begin
                    $error("fault: expected %b, got %b", want_rsp.fault, rsp_item.fault);
                    mismatch_count++;
                end
            end
        end
        if (rsp_stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("indexed_double_ended_queue_unit_tb NOT OK");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        stim_row_t row;
        dq_in_t    it;
        bit        mirror_sides;
        int        occ;
        int        pick;

        // Empty queue: every read and indexed write is refused, as are undefined codes.
        add_row(CMD_FRONT,      0,   32'h0,         1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        add_row(CMD_BACK,       0,   32'h0,         1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        add_row(CMD_READ_IDX,   0,   32'h0,         1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        add_row(CMD_WRITE_IDX,  511, 32'hFFFF_FFFF, 1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        add_row(CMD_UNDEF_6,    0,   32'h0,         1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        add_row(CMD_UNDEF_7,    511, 32'hFFFF_FFFF, 1'b1, {32'h0, 10'd0, 1'b1, 1'b1});
        // One stack filled while the other is empty: ends come from the same stack.
        add_row(CMD_PUSH_BACK,  0,   32'hFFFF_FFFF, 1'b1, {32'h0, 10'd1, 1'b0, 1'b0});
        add_row(CMD_FRONT,      0,   32'h0,         1'b0, '0);
        add_row(CMD_BACK,       0,   32'h0,         1'b0, '0);
        add_row(CMD_PUSH_FRONT, 511, 32'h0,         1'b1, {32'h0, 10'd2, 1'b0, 1'b0});
        add_row(CMD_PUSH_FRONT, 0,   32'hA5A5_A5A5, 1'b0, '0);
        add_row(CMD_READ_IDX,   0,   32'h0,         1'b0, '0);
        add_row(CMD_READ_IDX,   2,   32'h0,         1'b0, '0);
        add_row(CMD_READ_IDX,   3,   32'h0,         1'b1, {32'h0, 10'd3, 1'b0, 1'b1});
        add_row(CMD_READ_IDX,   511, 32'h0,         1'b1, {32'h0, 10'd3, 1'b0, 1'b1});
        add_row(CMD_WRITE_IDX,  1,   32'h1234_5678, 1'b0, '0);
        add_row(CMD_READ_IDX,   1,   32'h0,         1'b0, '0);
        add_row(CMD_WRITE_IDX,  3,   32'h5A5A_5A5A, 1'b1, {32'h0, 10'd3, 1'b0, 1'b1});
        add_row(CMD_FRONT,      0,   32'h0,         1'b0, '0);
        add_row(CMD_BACK,       0,   32'h0,         1'b0, '0);
        add_row(CMD_UNDEF_7,    511, 32'hFFFF_FFFF, 1'b1, {32'h0, 10'd3, 1'b0, 1'b1});

        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Only one stack can be empty first in a run, so the side is picked at random.
        mirror_sides = $urandom_range(0, 1);
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (mirror_sides)
            begin
                case (row.item.cmd)
                    CMD_PUSH_FRONT: row.item.cmd = CMD_PUSH_BACK;
                    CMD_PUSH_BACK:  row.item.cmd = CMD_PUSH_FRONT;
                    CMD_FRONT:      row.item.cmd = CMD_BACK;
                    CMD_BACK:       row.item.cmd = CMD_FRONT;
                    default:        row.item.cmd = row.item.cmd;
                endcase
            end
            send_cmd(row.item, row.has_fixed, row.result);
        end

        // Random commands, push-heavy enough that both stacks fill up.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 0 || n == RANDOM_ITEMS / 2)
                drain_pause();
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                sender_idle = 1'b0;
                rsp_stall_on = 1'b0;
            end
            occ = shadow_front_count + shadow_back_count;
            pick = $urandom_range(0, 99);
            if (pick < 22)
                it.cmd = CMD_PUSH_FRONT;
            else if (pick < 44)
                it.cmd = CMD_PUSH_BACK;
            else if (pick < 61)
                it.cmd = CMD_READ_IDX;
            else if (pick < 78)
                it.cmd = CMD_WRITE_IDX;
            else if (pick < 86)
                it.cmd = CMD_FRONT;
            else if (pick < 94)
                it.cmd = CMD_BACK;
            else
                it.cmd = $urandom_range(0, 1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
            // Mostly valid positions, some just past the end, some anywhere.
            pick = $urandom_range(0, 9);
            if (pick < 7 && occ > 0)
                it.position = POS_W'($urandom_range(0, occ - 1));
            else if (pick == 7 && occ <= 511)
                it.position = POS_W'(occ);
            else
                it.position = POS_W'($urandom_range(0, 511));
            pick = $urandom_range(0, 15);
            if (pick == 0)
                it.item_value = 32'h0;
            else if (pick == 1)
                it.item_value = 32'hFFFF_FFFF;
            else
                it.item_value = $urandom;
            send_cmd(it, 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        // Let every result come back, then watch for stray ones.
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("indexed_double_ended_queue_unit_tb OK");
        else
            $display("indexed_double_ended_queue_unit_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
src/idq_pkg.sv
src/idq_ram.sv
src/idq_ctrl.sv
src/idq_datapath.sv
src/indexed_double_ended_queue_unit.sv
tb/indexed_double_ended_queue_unit_tb.sv
